// ----- rtl/core/tnmh_pkg.sv -----
// shared types, constants and helpers for the top-k nearest max-heap
`default_nettype none
package tnmh_pkg;

    localparam int MAX_NEIGHBORS = 16;
    localparam int ADDR_W  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int CNT_W   = $clog2(MAX_NEIGHBORS + 1);
    localparam int CHILD_W = CNT_W + 1;
    localparam int ID_W    = 32;
    localparam int DIST_W  = 32;
    localparam int POS_W   = 6;
    localparam int K_W     = 7;

    localparam logic REQ_OFFER = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] distance;
    } entry_t;

    localparam entry_t EMPTY_ENTRY = '{id: '1, distance: '1};

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_b;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_data;
        logic              clr_all;
    } mem_req_t;

    typedef struct packed {
        logic [ID_W-1:0]   index;
        logic [DIST_W-1:0] distance;
        logic [POS_W-1:0]  position;
        logic              last;
    } res_t;

    // clamp the configured neighbor count into 1..MAX_NEIGHBORS
    function automatic logic [CNT_W-1:0] eff_k(input logic [K_W-1:0] nn);
        logic [CNT_W-1:0] k;
        if (nn == '0)
        begin
            k = CNT_W'(1);
        end
        else if (int'(nn) > MAX_NEIGHBORS)
        begin
            k = CNT_W'(MAX_NEIGHBORS);
        end
        else
        begin
            k = CNT_W'(nn);
        end
        return k;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/tnmh_heap_mem.sv -----
// heap storage: two read ports, one write port, per-entry valid flags
`default_nettype none
module tnmh_heap_mem
    import tnmh_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mem_req_t mem_req,
    output entry_t        rd_data_a,
    output entry_t        rd_data_b
);

    entry_t                   mem [MAX_NEIGHBORS];
    logic [MAX_NEIGHBORS-1:0] vld_reg;
    entry_t                   qa_reg;
    entry_t                   qb_reg;
    logic                     qa_vld_reg;
    logic                     qb_vld_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
        if (mem_req.rd_en)
        begin
            qa_reg <= mem[mem_req.rd_addr_a];
            qb_reg <= mem[mem_req.rd_addr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            qa_vld_reg <= 1'b0;
            qb_vld_reg <= 1'b0;
        end
        else
        begin
            if (mem_req.clr_all)
            begin
                vld_reg <= '0;
            end
            else if (mem_req.wr_en)
            begin
                vld_reg[mem_req.wr_addr] <= 1'b1;
            end
            if (mem_req.rd_en)
            begin
                qa_vld_reg <= vld_reg[mem_req.rd_addr_a];
                qb_vld_reg <= vld_reg[mem_req.rd_addr_b];
            end
        end
    end

    // entries never written since reset or drain read as empty
    assign rd_data_a = qa_vld_reg ? qa_reg : EMPTY_ENTRY;
    assign rd_data_b = qb_vld_reg ? qb_reg : EMPTY_ENTRY;

endmodule
`default_nettype wire

// ----- rtl/core/tnmh_engine.sv -----
// sequencer: duplicate scan, sift-down and heap-sort drain over the heap memory
`default_nettype none
module tnmh_engine
    import tnmh_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              req_type,
    input  wire logic [ID_W-1:0]   cand_index,
    input  wire logic [DIST_W-1:0] cand_dist,
    input  wire logic [K_W-1:0]    k_cfg,
    output logic                   busy,
    output mem_req_t               mem_req,
    input  wire entry_t            rd_data_a,
    input  wire entry_t            rd_data_b,
    input  wire logic              res_ready,
    output logic                   res_emit,
    output res_t                   res
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DUP_RD   = 3'd1;
    localparam logic [2:0] S_DUP_CHK  = 3'd2;
    localparam logic [2:0] S_SIFT_RD  = 3'd3;
    localparam logic [2:0] S_SIFT_CHK = 3'd4;
    localparam logic [2:0] S_DR_RD    = 3'd5;
    localparam logic [2:0] S_DR_EMIT  = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  size_reg, size_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  base_reg, base_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic              drain_reg, drain_next;
    logic              drop_reg, drop_next;
    entry_t            cand_reg, cand_next;

    logic [CHILD_W-1:0] child_l;
    logic [CHILD_W-1:0] child_r;
    logic [CHILD_W-1:0] base_p1;
    logic [CHILD_W-1:0] base_p2;
    logic [CNT_W-1:0]   n_m1;
    logic [CNT_W-1:0]   k_in;
    logic               hit_a;
    logic               hit_b;
    logic               root_fail;
    logic               drop_any;
    logic               go_r;
    logic               go_l;

    assign child_l  = (CHILD_W'(pos_reg) << 1) + CHILD_W'(1);
    assign child_r  = (CHILD_W'(pos_reg) << 1) + CHILD_W'(2);
    assign base_p1  = CHILD_W'(base_reg) + CHILD_W'(1);
    assign base_p2  = CHILD_W'(base_reg) + CHILD_W'(2);
    assign n_m1     = n_reg - CNT_W'(1);
    assign k_in     = eff_k(k_cfg);

    assign hit_a     = (rd_data_a.id == cand_reg.id);
    assign hit_b     = (base_p1 < CHILD_W'(k_reg)) && (rd_data_b.id == cand_reg.id);
    assign root_fail = (base_reg == '0) && (cand_reg.distance >= rd_data_a.distance);
    assign drop_any  = drop_reg | hit_a | hit_b | root_fail;

    // right child wins only when strictly larger than both left child and candidate
    assign go_r = (child_r < CHILD_W'(size_reg))
                  && (rd_data_b.distance > rd_data_a.distance)
                  && (rd_data_b.distance > cand_reg.distance);
    assign go_l = (child_l < CHILD_W'(size_reg)) && (rd_data_a.distance > cand_reg.distance);

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        size_next  = size_reg;
        n_next     = n_reg;
        base_next  = base_reg;
        pos_next   = pos_reg;
        drain_next = drain_reg;
        drop_next  = drop_reg;
        cand_next  = cand_reg;
        mem_req    = '0;
        res_emit   = 1'b0;
        res        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    k_next    = k_in;
                    cand_next = '{id: cand_index, distance: cand_dist};
                    drop_next = 1'b0;
                    base_next = '0;
                    if (req_type == REQ_DRAIN)
                    begin
                        n_next     = k_in;
                        state_next = S_DR_RD;
                    end
                    else
                    begin
                        state_next = S_DUP_RD;
                    end
                end
            end
            S_DUP_RD:
            begin
                mem_req.rd_en     = 1'b1;
                mem_req.rd_addr_a = base_reg[ADDR_W-1:0];
                mem_req.rd_addr_b = base_p1[ADDR_W-1:0];
                state_next        = S_DUP_CHK;
            end
            S_DUP_CHK:
            begin
                drop_next = drop_any;
                if (base_p2 >= CHILD_W'(k_reg))
                begin
                    if (drop_any)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        pos_next   = '0;
                        size_next  = k_reg;
                        drain_next = 1'b0;
                        state_next = S_SIFT_RD;
                    end
                end
                else
                begin
                    base_next  = base_p2[CNT_W-1:0];
                    state_next = S_DUP_RD;
                end
            end
            S_SIFT_RD:
            begin
                mem_req.rd_en     = 1'b1;
                mem_req.rd_addr_a = child_l[ADDR_W-1:0];
                mem_req.rd_addr_b = child_r[ADDR_W-1:0];
                state_next        = S_SIFT_CHK;
            end
            S_SIFT_CHK:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = pos_reg;
                priority if (go_r)
                begin
                    mem_req.wr_data = rd_data_b;
                    pos_next        = child_r[ADDR_W-1:0];
                    state_next      = S_SIFT_RD;
                end
                else if (go_l)
                begin
                    mem_req.wr_data = rd_data_a;
                    pos_next        = child_l[ADDR_W-1:0];
                    state_next      = S_SIFT_RD;
                end
                else
                begin
                    mem_req.wr_data = cand_reg;
                    if (drain_reg)
                    begin
                        n_next     = size_reg;
                        state_next = S_DR_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_DR_RD:
            begin
                mem_req.rd_en     = 1'b1;
                mem_req.rd_addr_a = '0;
                mem_req.rd_addr_b = n_m1[ADDR_W-1:0];
                state_next        = S_DR_EMIT;
            end
            S_DR_EMIT:
            begin
                if (res_ready)
                begin
                    res_emit     = 1'b1;
                    res.index    = rd_data_a.id;
                    res.distance = rd_data_a.distance;
                    res.position = POS_W'(n_m1);
                    res.last     = (n_m1 == '0);
                    if (n_m1 == '0)
                    begin
                        mem_req.clr_all = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        cand_next  = rd_data_b;
                        size_next  = n_m1;
                        pos_next   = '0;
                        drain_next = 1'b1;
                        state_next = S_SIFT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            size_reg  <= '0;
            n_reg     <= '0;
            base_reg  <= '0;
            pos_reg   <= '0;
            drain_reg <= 1'b0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            size_reg  <= size_next;
            n_reg     <= n_next;
            base_reg  <= base_next;
            pos_reg   <= pos_next;
            drain_reg <= drain_next;
            drop_reg  <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
    end

    a_emit_ready: assert property (@(posedge clk) disable iff (!rst_n)
        res_emit |-> res_ready)
        else $error("result emitted while output register is full");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (res_emit && res.last) |=> (state_reg == S_IDLE))
        else $error("drain continued after its last result");

    a_sift_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SIFT_RD) |-> (CNT_W'(pos_reg) < size_reg))
        else $error("sift position outside the active heap");

    a_write_in_k: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> (CNT_W'(mem_req.wr_addr) < k_reg))
        else $error("heap write beyond the neighbor count");

    a_no_wr_clr: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.clr_all |-> !mem_req.wr_en && (state_reg == S_DR_EMIT))
        else $error("heap cleared outside the end of a drain");

endmodule
`default_nettype wire

// ----- rtl/core/topk_nearest_max_heap.sv -----
// top level: k nearest neighbors kept in a bounded max-heap
//
// input channel (in_valid/in_stall): req_type 0 offers (cand_index, cand_dist),
// req_type 1 drains the heap. one transfer is taken only while the engine is
// idle; in_stall is high for the whole time an item is processed.
// an offer is dropped if its distance is not below the root or its index is
// already among the first k entries; otherwise it replaces the root and sifts
// down. the duplicate scan reads two heap entries at a time over the two
// heap read ports; each sift level is a read step then a compare/write step.
// a drain emits k results on the output channel (out_valid/out_stall), largest
// distance first, tagged with the sorted position and last on position 0.
// between results the last heap entry is sifted down from the root through
// the heap memory. after a drain the heap is empty. the output register
// frees the engine while a result waits; a stalled receiver holds the drain
// in place. reset empties the heap through per-entry valid flags and sets
// num_neighbors (APB offset 0) to 16.
`default_nettype none
module topk_nearest_max_heap
    import tnmh_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              req_type,
    input  wire logic [ID_W-1:0]   cand_index,
    input  wire logic [DIST_W-1:0] cand_dist,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [ID_W-1:0]        out_index,
    output logic [DIST_W-1:0]      out_dist,
    output logic [POS_W-1:0]       out_position,
    output logic                   last
);

    logic [K_W-1:0] num_neighbors_reg;
    logic           busy;
    logic           res_ready;
    logic           res_emit;
    res_t           res;
    mem_req_t       mem_req;
    entry_t         rd_data_a;
    entry_t         rd_data_b;
    logic           out_valid_reg, out_valid_next;
    res_t           out_reg;
    logic           reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == 1'b0);
    assign prdata  = reg_hit ? {{(32 - K_W){1'b0}}, num_neighbors_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_neighbors_reg <= K_W'(16);
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            num_neighbors_reg <= pwdata[K_W-1:0];
        end
    end

    assign in_stall = busy;

    tnmh_heap_mem u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .mem_req   (mem_req),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    tnmh_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .req_type   (req_type),
        .cand_index (cand_index),
        .cand_dist  (cand_dist),
        .k_cfg      (num_neighbors_reg),
        .busy       (busy),
        .mem_req    (mem_req),
        .rd_data_a  (rd_data_a),
        .rd_data_b  (rd_data_b),
        .res_ready  (res_ready),
        .res_emit   (res_emit),
        .res        (res)
    );

    // output register, refilled in the cycle its transfer completes
    assign res_ready      = !out_valid_reg || !out_stall;
    assign out_valid_next = res_emit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_emit)
        begin
            out_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_index    = out_reg.index;
    assign out_dist     = out_reg.distance;
    assign out_position = out_reg.position;
    assign last         = out_reg.last;

endmodule
`default_nettype wire
